### design/jnl_pkg.sv
package jnl_pkg;

  // character classes handed from the front to the back
  typedef enum logic [2:0] {
    CC_WS,
    CC_MINUS,
    CC_PLUS,
    CC_DOT,
    CC_EXP,
    CC_DIGIT,
    CC_OTHER
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
    logic        begin_new;
  } item_t;

  typedef struct packed {
    logic [1:0]  parse_status;
    logic        consumed;
    logic        is_negative;
    logic [31:0] mantissa;
    logic [5:0]  frac_digits;
    logic        exp_sign_neg;
    logic [13:0] exp_magnitude;
    logic        mant_overflow;
  } result_t;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_INT   = 2'd1;
  localparam logic [1:0] PH_FRAC  = 2'd2;
  localparam logic [1:0] PH_EXP   = 2'd3;

  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_COMPLETE   = 2'd1;
  localparam logic [1:0] ST_ERROR      = 2'd2;

  localparam logic [5:0]  FRAC_MAX = 6'd63;
  localparam logic [13:0] EXP_MAX  = 14'd9999;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

### design/jnl_front.sv
module jnl_front import jnl_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_i,
  input  logic       begin_new_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output item_t      push_item_o
);

  logic [3:0] dig_off;

  // ascii digits carry their value in the low nibble
  assign dig_off = char_i[3:0];

  always_comb begin
    push_item_o.begin_new = begin_new_i;
    push_item_o.digit     = dig_off;
    priority if (char_i >= CH_ZERO && char_i <= CH_NINE) begin
      push_item_o.cls = CC_DIGIT;
    end else if (char_i == CH_SPACE || char_i == CH_LF || char_i == CH_CR ||
                 char_i == CH_TAB) begin
      push_item_o.cls = CC_WS;
    end else if (char_i == CH_MINUS) begin
      push_item_o.cls = CC_MINUS;
    end else if (char_i == CH_PLUS) begin
      push_item_o.cls = CC_PLUS;
    end else if (char_i == CH_DOT) begin
      push_item_o.cls = CC_DOT;
    end else if (char_i == CH_E_LO || char_i == CH_E_UP) begin
      push_item_o.cls = CC_EXP;
    end else begin
      push_item_o.cls = CC_OTHER;
    end
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

### design/jnl_queue.sv
module jnl_queue import jnl_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  item_t wr_item_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output item_t rd_item_o
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  item_t            mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign wr_ready_o = (cnt_q != FullCnt);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

### design/jnl_back.sv
module jnl_back import jnl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  output logic    item_ready_o,
  input  item_t   item_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  logic [1:0]  phase_q, phase_d;
  logic        dreq_q, dreq_d;
  logic        sgn_ok_q, sgn_ok_d;
  logic        neg_q, neg_d;
  logic        eneg_q, eneg_d;
  logic [31:0] mant_q, mant_d;
  logic [5:0]  frac_q, frac_d;
  logic [13:0] exp_q, exp_d;
  logic [1:0]  status_q, status_d;
  logic        ovf_q, ovf_d;
  logic        used_q, used_d;
  logic        valid_q;
  logic        pop;

  // values after an optional begin_new clear
  logic [1:0]  c_phase;
  logic        c_dreq, c_sgn_ok, c_neg, c_eneg, c_ovf;
  logic [31:0] c_mant;
  logic [5:0]  c_frac;
  logic [13:0] c_exp;
  logic [1:0]  c_status;

  logic [35:0] mant_x10;
  logic [17:0] exp_x10;

  assign pop          = item_valid_i && (!valid_q || res_ready_i);
  assign item_ready_o = !valid_q || res_ready_i;

  always_comb begin
    if (item_i.begin_new) begin
      c_phase  = PH_START;
      c_dreq   = 1'b0;
      c_sgn_ok = 1'b0;
      c_neg    = 1'b0;
      c_eneg   = 1'b0;
      c_mant   = '0;
      c_frac   = '0;
      c_exp    = '0;
      c_status = ST_INCOMPLETE;
      c_ovf    = 1'b0;
    end else begin
      c_phase  = phase_q;
      c_dreq   = dreq_q;
      c_sgn_ok = sgn_ok_q;
      c_neg    = neg_q;
      c_eneg   = eneg_q;
      c_mant   = mant_q;
      c_frac   = frac_q;
      c_exp    = exp_q;
      c_status = status_q;
      c_ovf    = ovf_q;
    end
  end

  // times ten as two shifted adds
  assign mant_x10 = ({4'b0, c_mant} << 3) + ({4'b0, c_mant} << 1) + {32'b0, item_i.digit};
  assign exp_x10  = ({4'b0, c_exp} << 3) + ({4'b0, c_exp} << 1) + {14'b0, item_i.digit};

  always_comb begin
    phase_d  = c_phase;
    dreq_d   = c_dreq;
    sgn_ok_d = c_sgn_ok;
    neg_d    = c_neg;
    eneg_d   = c_eneg;
    mant_d   = c_mant;
    frac_d   = c_frac;
    exp_d    = c_exp;
    status_d = c_status;
    ovf_d    = c_ovf;
    used_d   = 1'b0;
    if (c_status == ST_INCOMPLETE) begin
      unique case (c_phase)
        PH_START: begin
          if (item_i.cls == CC_WS) begin
            used_d = 1'b1;
          end else if (item_i.cls == CC_MINUS) begin
            neg_d   = 1'b1;
            dreq_d  = 1'b1;
            phase_d = PH_INT;
            used_d  = 1'b1;
          end else if (item_i.cls == CC_DIGIT) begin
            phase_d = PH_INT;
            mant_d  = mant_x10[31:0];
            ovf_d   = c_ovf | (mant_x10[35:32] != '0);
            dreq_d  = 1'b0;
            used_d  = 1'b1;
          end else begin
            status_d = ST_ERROR;
          end
        end
        PH_INT, PH_FRAC: begin
          if (item_i.cls == CC_DIGIT) begin
            mant_d = mant_x10[31:0];
            ovf_d  = c_ovf | (mant_x10[35:32] != '0);
            dreq_d = 1'b0;
            if (c_phase == PH_FRAC && c_frac != FRAC_MAX) begin
              frac_d = c_frac + 1'b1;
            end
            used_d = 1'b1;
          end else if (item_i.cls == CC_DOT && c_phase == PH_INT) begin
            if (c_dreq) begin
              status_d = ST_ERROR;
            end else begin
              phase_d = PH_FRAC;
              dreq_d  = 1'b1;
              used_d  = 1'b1;
            end
          end else if (item_i.cls == CC_EXP) begin
            if (c_dreq) begin
              status_d = ST_ERROR;
            end else begin
              phase_d  = PH_EXP;
              dreq_d   = 1'b1;
              sgn_ok_d = 1'b1;
              used_d   = 1'b1;
            end
          end else begin
            status_d = c_dreq ? ST_ERROR : ST_COMPLETE;
          end
        end
        PH_EXP: begin
          if (item_i.cls == CC_DIGIT) begin
            exp_d    = (exp_x10 > {4'b0, EXP_MAX}) ? EXP_MAX : exp_x10[13:0];
            sgn_ok_d = 1'b0;
            dreq_d   = 1'b0;
            used_d   = 1'b1;
          end else if (item_i.cls == CC_PLUS || item_i.cls == CC_MINUS) begin
            if (c_sgn_ok) begin
              if (item_i.cls == CC_MINUS) begin
                eneg_d = 1'b1;
              end
              sgn_ok_d = 1'b0;
              dreq_d   = 1'b1;
              used_d   = 1'b1;
            end else begin
              status_d = ST_ERROR;
            end
          end else begin
            status_d = c_dreq ? ST_ERROR : ST_COMPLETE;
          end
        end
        default: begin
          status_d = c_status;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      dreq_q   <= 1'b0;
      sgn_ok_q <= 1'b0;
      neg_q    <= 1'b0;
      eneg_q   <= 1'b0;
      mant_q   <= '0;
      frac_q   <= '0;
      exp_q    <= '0;
      status_q <= ST_INCOMPLETE;
      ovf_q    <= 1'b0;
      used_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      if (pop) begin
        phase_q  <= phase_d;
        dreq_q   <= dreq_d;
        sgn_ok_q <= sgn_ok_d;
        neg_q    <= neg_d;
        eneg_q   <= eneg_d;
        mant_q   <= mant_d;
        frac_q   <= frac_d;
        exp_q    <= exp_d;
        status_q <= status_d;
        ovf_q    <= ovf_d;
        used_q   <= used_d;
        valid_q  <= 1'b1;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // the state registers double as the result register
  assign res_valid_o         = valid_q;
  assign res_o.parse_status  = status_q;
  assign res_o.consumed      = used_q;
  assign res_o.is_negative   = neg_q;
  assign res_o.mantissa      = mant_q;
  assign res_o.frac_digits   = frac_q;
  assign res_o.exp_sign_neg  = eneg_q;
  assign res_o.exp_magnitude = exp_q;
  assign res_o.mant_overflow = ovf_q;

endmodule

### design/json_number_lexer.sv
// path: an accepted request is written into the queue, then popped into the lexer state
//   registers, whose update makes the result valid; a stalled output holds it in the queue
// throughput: one character per cycle while m_axis_tready does not stall the output
// reset: rst_ni low clears the queue, the lexer state and the output valid
//   at once; the block is ready to take requests as soon as rst_ni is released
module json_number_lexer import jnl_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_in
  input  logic [0:0]  s_axis_tuser,   // begin_new
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // parse_status, consumed, is_negative, mantissa, frac_digits, exp_sign_neg,
  // exp_magnitude, mant_overflow, zero fill
  output logic [63:0] m_axis_tdata
);

  logic    push_valid, push_ready;
  item_t   push_item;
  logic    q_valid, q_ready;
  item_t   q_item;
  result_t res;

  jnl_front u_front (
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .char_i       (s_axis_tdata),
    .begin_new_i  (s_axis_tuser[0]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  jnl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_item_i  (push_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  jnl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {6'b0,
                         res.mant_overflow,
                         res.exp_magnitude,
                         res.exp_sign_neg,
                         res.frac_digits,
                         res.mantissa,
                         res.is_negative,
                         res.consumed,
                         res.parse_status};

  // a queue that pushes back must be holding something for the lexer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_valid)
    else $error("queue full while empty");

  // a terminating or ignored character is never consumed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.parse_status != ST_INCOMPLETE) |-> !res.consumed)
    else $error("consumed with final status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.exp_magnitude <= EXP_MAX &&
                       (res.parse_status == ST_INCOMPLETE ||
                        res.parse_status == ST_COMPLETE ||
                        res.parse_status == ST_ERROR)))
    else $error("exponent saturation or status code broken");

endmodule

### test/tb_json_number_lexer.sv
module tb_json_number_lexer import jnl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  phase;
    logic        need_digit;
    logic        sign_ok;
    logic        neg;
    logic        exp_neg;
    logic [31:0] mant;
    logic [5:0]  frac;
    logic [13:0] expo;
    logic [1:0]  status;
    logic        ovf;
  } lexer_t;

  // one directed request, with status and consumed typed in where obvious
  typedef struct packed {
    logic [7:0] ch;
    logic       bnew;
    logic       typed;
    logic [1:0] st;
    logic       used;
  } probe_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // char_in
  logic [0:0]  s_axis_tuser = '0;   // begin_new
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // parse_status, consumed, is_negative, mantissa, frac_digits, exp_sign_neg,
  // exp_magnitude, mant_overflow, zero fill
  logic [63:0] m_axis_tdata;

  lexer_t  lex = '0;
  result_t pending_results [$];
  result_t got, want;
  int      mismatches = 0;
  int      result_idx = 0;
  int      live_count = 0;
  int      tx_pct = 0;
  int      rx_pct = 20;
  int      rx_stall = 0;
  bit      quiet = 1'b0;

  probe_t directed_rows [25] = '{
    '{CH_SPACE, 1'b0, 1'b1, ST_INCOMPLETE, 1'b1},
    '{CH_TAB,   1'b0, 1'b1, ST_INCOMPLETE, 1'b1},
    '{CH_LF,    1'b0, 1'b1, ST_INCOMPLETE, 1'b1},
    '{CH_CR,    1'b0, 1'b1, ST_INCOMPLETE, 1'b1},
    '{CH_MINUS, 1'b0, 1'b1, ST_INCOMPLETE, 1'b1},
    '{CH_DOT,   1'b0, 1'b1, ST_ERROR,      1'b0},
    '{"5",      1'b0, 1'b1, ST_ERROR,      1'b0},
    '{CH_ZERO,  1'b1, 1'b0, ST_INCOMPLETE, 1'b0},
    '{CH_DOT,   1'b0, 1'b0, ST_INCOMPLETE, 1'b0},
    '{"5",      1'b0, 1'b0, ST_INCOMPLETE, 1'b0},
    '{CH_E_UP,  1'b0, 1'b0, ST_INCOMPLETE, 1'b0},
    '{CH_MINUS, 1'b0, 1'b0, ST_INCOMPLETE, 1'b0},
    '{"1",      1'b0, 1'b0, ST_INCOMPLETE, 1'b0},
    '{"2",      1'b0, 1'b0, ST_INCOMPLETE, 1'b0},
    '{"3",      1'b0, 1'b0, ST_INCOMPLETE, 1'b0},
    '{"4",      1'b0, 1'b0, ST_INCOMPLETE, 1'b0},
    '{"5",      1'b0, 1'b0, ST_INCOMPLETE, 1'b0},
    '{CH_PLUS,  1'b0, 1'b1, ST_ERROR,      1'b0},
    '{8'hFF,    1'b1, 1'b1, ST_ERROR,      1'b0},
    '{CH_NINE,  1'b1, 1'b0, ST_INCOMPLETE, 1'b0},
    '{CH_E_LO,  1'b0, 1'b0, ST_INCOMPLETE, 1'b0},
    '{CH_PLUS,  1'b0, 1'b0, ST_INCOMPLETE, 1'b0},
    '{"x",      1'b0, 1'b1, ST_ERROR,      1'b0},
    '{"3",      1'b1, 1'b0, ST_INCOMPLETE, 1'b0},
    '{CH_PLUS,  1'b0, 1'b1, ST_COMPLETE,   1'b0}
  };

  json_number_lexer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void push_mant_digit(input logic [3:0] d);
    logic [35:0] wide;
    wide = lex.mant * 36'd10 + d;
    if (wide[35:32] != 4'd0) lex.ovf = 1'b1;
    lex.mant = wide[31:0];
    lex.need_digit = 1'b0;
  endfunction

  function automatic result_t lex_char(input logic [7:0] c, input logic bnew);
    logic       is_dig;
    logic [3:0] dval;
    logic       used;
    logic [17:0] ev;
    result_t    r;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    dval = is_dig ? c[3:0] : 4'd0;
    used = 1'b0;
    if (bnew) lex = '0;
    if (lex.status == ST_INCOMPLETE) begin
      case (lex.phase)
        PH_START: begin
          if (c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB) begin
            used = 1'b1;
          end else if (c == CH_MINUS) begin
            lex.neg = 1'b1;
            lex.need_digit = 1'b1;
            lex.phase = PH_INT;
            used = 1'b1;
          end else if (is_dig) begin
            lex.phase = PH_INT;
            push_mant_digit(dval);
            used = 1'b1;
          end else begin
            lex.status = ST_ERROR;
          end
        end
        PH_INT, PH_FRAC: begin
          if (is_dig) begin
            push_mant_digit(dval);
            if (lex.phase == PH_FRAC && lex.frac != FRAC_MAX) lex.frac = lex.frac + 6'd1;
            used = 1'b1;
          end else if (c == CH_DOT && lex.phase == PH_INT) begin
            if (lex.need_digit) begin
              lex.status = ST_ERROR;
            end else begin
              lex.phase = PH_FRAC;
              lex.need_digit = 1'b1;
              used = 1'b1;
            end
          end else if (c == CH_E_LO || c == CH_E_UP) begin
            if (lex.need_digit) begin
              lex.status = ST_ERROR;
            end else begin
              lex.phase = PH_EXP;
              lex.need_digit = 1'b1;
              lex.sign_ok = 1'b1;
              used = 1'b1;
            end
          end else begin
            lex.status = lex.need_digit ? ST_ERROR : ST_COMPLETE;
          end
        end
        default: begin
          if (is_dig) begin
            ev = lex.expo * 18'd10 + dval;
            lex.expo = (ev > EXP_MAX) ? EXP_MAX : ev[13:0];
            lex.sign_ok = 1'b0;
            lex.need_digit = 1'b0;
            used = 1'b1;
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            if (lex.sign_ok) begin
              if (c == CH_MINUS) lex.exp_neg = 1'b1;
              lex.sign_ok = 1'b0;
              lex.need_digit = 1'b1;
              used = 1'b1;
            end else begin
              lex.status = ST_ERROR;
            end
          end else begin
            lex.status = lex.need_digit ? ST_ERROR : ST_COMPLETE;
          end
        end
      endcase
    end
    r.parse_status  = lex.status;
    r.consumed      = used;
    r.is_negative   = lex.neg;
    r.mantissa      = lex.mant;
    r.frac_digits   = lex.frac;
    r.exp_sign_neg  = lex.exp_neg;
    r.exp_magnitude = lex.expo;
    r.mant_overflow = lex.ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] g,
                                 input logic [63:0] w);
    $display("result %0d: %s is %0h, expected %0h", result_idx, field, g, w);
    mismatches++;
  endtask

  // drives one request, waits for it to be taken, then queues its prediction
  task automatic send_char(input logic [7:0] c, input logic bnew, input logic typed,
                           input logic [1:0] st, input logic used);
    result_t r;
    if (!quiet && $urandom_range(0, 99) < tx_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= bnew;
    do @(posedge clk_i); while (!s_axis_tready);
    live_count++;
    r = lex_char(c, bnew);
    if (typed) begin
      r.parse_status = st;
      r.consumed = used;
    end
    pending_results.push_back(r);
  endtask

  initial begin
    logic [7:0] txt [$];
    int         n;
    bit         drained;
    drained = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].bnew, directed_rows[i].typed,
                directed_rows[i].st, directed_rows[i].used);

    while (live_count < 1250) begin
      quiet = (live_count >= 1100);
      case ($urandom_range(0, 3))
        0, 1: tx_pct = 0;
        2: tx_pct = 15;
        default: tx_pct = 40;
      endcase
      if (!drained && live_count > 600) begin
        // hold the stream until the lexer has returned everything
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        // raw noise, begin_new at random
        repeat ($urandom_range(1, 6))
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                    ST_INCOMPLETE, 1'b0);
      end else begin
        txt.delete();
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 3))
            0: txt.push_back(CH_SPACE);
            1: txt.push_back(CH_TAB);
            2: txt.push_back(CH_LF);
            default: txt.push_back(CH_CR);
          endcase
        end
        if ($urandom_range(0, 1) == 0) txt.push_back(CH_MINUS);
        // long integer parts can push the mantissa past 32 bits
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
        repeat (n) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 0) begin
          txt.push_back(CH_DOT);
          n = ($urandom_range(0, 24) == 0) ? $urandom_range(62, 66) : $urandom_range(1, 4);
          repeat (n) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 2) == 0) begin
          txt.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
          case ($urandom_range(0, 2))
            0: txt.push_back(CH_PLUS);
            1: txt.push_back(CH_MINUS);
            default: ;
          endcase
          repeat ($urandom_range(1, 5)) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        case ($urandom_range(0, 7))
          0: txt.push_back(",");
          1: txt.push_back("]");
          2: txt.push_back("}");
          3: txt.push_back(CH_SPACE);
          4: txt.push_back(CH_DOT);
          5: txt.push_back(CH_PLUS);
          6: txt.push_back(CH_MINUS);
          default: txt.push_back(8'($urandom_range(0, 255)));
        endcase
        repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom_range(0, 255)));
        // broken number: one character replaced by any byte
        if ($urandom_range(0, 5) == 0)
          txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
        foreach (txt[k]) send_char(txt[k], k == 0, 1'b0, ST_INCOMPLETE, 1'b0);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** json_number_lexer: PASSED **");
    end else begin
      $display("** json_number_lexer: FAILED **");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) rx_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_pct) begin
      rx_stall = $urandom_range(1, 5) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.parse_status  = m_axis_tdata[1:0];
      got.consumed      = m_axis_tdata[2];
      got.is_negative   = m_axis_tdata[3];
      got.mantissa      = m_axis_tdata[35:4];
      got.frac_digits   = m_axis_tdata[41:36];
      got.exp_sign_neg  = m_axis_tdata[42];
      got.exp_magnitude = m_axis_tdata[56:43];
      got.mant_overflow = m_axis_tdata[57];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.parse_status !== want.parse_status)
          report_mismatch("parse_status", got.parse_status, want.parse_status);
        if (got.consumed !== want.consumed)
          report_mismatch("consumed", got.consumed, want.consumed);
        if (got.is_negative !== want.is_negative)
          report_mismatch("is_negative", got.is_negative, want.is_negative);
        if (got.mantissa !== want.mantissa)
          report_mismatch("mantissa", got.mantissa, want.mantissa);
        if (got.frac_digits !== want.frac_digits)
          report_mismatch("frac_digits", got.frac_digits, want.frac_digits);
        if (got.exp_sign_neg !== want.exp_sign_neg)
          report_mismatch("exp_sign_neg", got.exp_sign_neg, want.exp_sign_neg);
        if (got.exp_magnitude !== want.exp_magnitude)
          report_mismatch("exp_magnitude", got.exp_magnitude, want.exp_magnitude);
        if (got.mant_overflow !== want.mant_overflow)
          report_mismatch("mant_overflow", got.mant_overflow, want.mant_overflow);
        if (m_axis_tdata[63:58] !== 6'd0)
          report_mismatch("zero fill", m_axis_tdata[63:58], '0);
      end
      result_idx++;
    end
  end

  initial begin
    #5ms;
    $display("** json_number_lexer: FAILED **");
    $finish;
  end

endmodule

### filelist.f
design/jnl_pkg.sv
design/jnl_front.sv
design/jnl_queue.sv
design/jnl_back.sv
design/json_number_lexer.sv
test/tb_json_number_lexer.sv
